/* src/pfsm_pkg.sv */
// shared types, constants and reset tables for the programmable state machine
package pfsm_pkg;

   // request kinds
   typedef enum logic [2:0] {
      KIND_STEP   = 3'd0,
      KIND_CHANGE = 3'd1,
      KIND_QUERY  = 3'd2,
      KIND_DELETE = 3'd3,
      KIND_PRUNE  = 3'd4
   } kind_type;

   // controller states
   typedef enum logic [1:0] {
      CTL_IDLE,
      CTL_SEED,
      CTL_EXPAND,
      CTL_FINISH
   } ctl_state_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic seed;
      logic expand;
      logic finish;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic is_reach;
      logic out_free;
   } status_type;

   localparam int unsigned BASE_STATES = 8;
   localparam int unsigned RESET_STATE = 5;

   localparam logic [2:0] RESET_NEXT0 [BASE_STATES] = '{3'd7, 3'd4, 3'd0, 3'd1,
                                                        3'd2, 3'd6, 3'd3, 3'd5};
   localparam logic [2:0] RESET_NEXT1 [BASE_STATES] = '{3'd6, 3'd3, 3'd2, 3'd2,
                                                        3'd5, 3'd1, 3'd7, 3'd4};

   // reset successor of a state; states past the base table loop to themselves
   function automatic int unsigned pfsm_reset_next(input logic sym, input int unsigned idx);
      int unsigned res;
      res = idx;
      if (idx < BASE_STATES) begin
         if (sym) begin
            res = int'(RESET_NEXT1[idx[2:0]]);
         end else begin
            res = int'(RESET_NEXT0[idx[2:0]]);
         end
      end
      return res;
   endfunction

endpackage

/* src/programmable_fsm_with_reachability_prune.sv */
// top level of the programmable state machine with reachability pruning
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  kind, symbol, target
//   rsp      out        rsp_valid/rsp_stall  current_state, refused, unreachable_mask,
//                                            any_unreachable
//
// one request at a time: step, change and delete go from the seed state straight to
// the finish state, while query and prune first pass through the successor expansion
// rounds, sharing one successor unit; the next request is taken the cycle after the
// result is issued, while that result may still wait in the output register.
// synchronous reset restores the reset table, state F and all states valid.
// a stalled result holds its fields; a finished item waits until the slot frees.
module programmable_fsm_with_reachability_prune
   import pfsm_pkg::*;
#(
   parameter int unsigned NUM_STATES = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_kind,
   input  logic       req_symbol,
   input  logic [2:0] req_target,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_current_state,
   output logic       rsp_refused,
   output logic [7:0] rsp_unreachable_mask,
   output logic       rsp_any_unreachable
);

   cmd_type    cmd;
   status_type status;

   // sequencing
   pfsm_ctrl #(.NUM_STATES(NUM_STATES)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // state, table and result
   pfsm_datapath #(.NUM_STATES(NUM_STATES)) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_kind             (req_kind),
      .req_symbol           (req_symbol),
      .req_target           (req_target),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_current_state    (rsp_current_state),
      .rsp_refused          (rsp_refused),
      .rsp_unreachable_mask (rsp_unreachable_mask),
      .rsp_any_unreachable  (rsp_any_unreachable)
   );

endmodule

/* src/pfsm_ctrl.sv */
// controller for request sequencing and reachability rounds
module pfsm_ctrl
   import pfsm_pkg::*;
#(
   parameter int unsigned NUM_STATES = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   localparam int unsigned CW = (NUM_STATES > 2) ? $clog2(NUM_STATES) : 1;
   localparam logic [CW-1:0] LAST_ROUND = CW'(NUM_STATES - 1);

   ctl_state_type state_ff, state_in;
   logic [CW-1:0] round_ff, round_in;

   // state and round counter registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_IDLE;
         round_ff <= '0;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CTL_IDLE: begin
            if (req_valid) state_in = CTL_SEED;
         end
         CTL_SEED: begin
            state_in = status.is_reach ? CTL_EXPAND : CTL_FINISH;
         end
         CTL_EXPAND: begin
            if (round_ff == LAST_ROUND) state_in = CTL_FINISH;
         end
         CTL_FINISH: begin
            if (status.out_free) state_in = CTL_IDLE;
         end
         default: state_in = CTL_IDLE;
      endcase
   end

   // outputs and round count
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      round_in  = round_ff;
      unique case (state_ff)
         CTL_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         CTL_SEED: begin
            cmd.seed = 1'b1;
            round_in = '0;
         end
         CTL_EXPAND: begin
            cmd.expand = 1'b1;
            round_in   = round_ff + 1'b1;
         end
         CTL_FINISH: begin
            cmd.finish = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

/* src/pfsm_datapath.sv */
// datapath: state, transition table, valid bits, successor unit and result register
module pfsm_datapath
   import pfsm_pkg::*;
#(
   parameter int unsigned NUM_STATES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic [2:0]  req_kind,
   input  logic        req_symbol,
   input  logic [2:0]  req_target,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_current_state,
   output logic        rsp_refused,
   output logic [7:0]  rsp_unreachable_mask,
   output logic        rsp_any_unreachable
);

   localparam int unsigned SW = (NUM_STATES > 2) ? $clog2(NUM_STATES) : 1;

   // captured request
   logic [2:0]    kind_ff;
   logic          symbol_ff;
   logic [2:0]    target_ff;

   // machine state
   logic [SW-1:0]         cur_ff, cur_in;
   logic [NUM_STATES-1:0] valid_ff, valid_in;
   logic [SW-1:0]         next0_ff [NUM_STATES];
   logic [SW-1:0]         next1_ff [NUM_STATES];
   logic [NUM_STATES-1:0] reached_ff, reached_in;

   // result register
   logic                  rsp_valid_ff;
   logic [2:0]            rsp_state_ff;
   logic                  rsp_refused_ff;
   logic [7:0]            rsp_mask_ff;

   logic [NUM_STATES-1:0] succ_src, succ_set, unreach;
   logic [SW-1:0]         step_next, tgt_idx;
   logic                  step_ok, tgt_ok, tbl_wr;
   logic                  refused_in;
   logic [7:0]            mask_in;

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff   <= req_kind;
         symbol_ff <= req_symbol;
         target_ff <= req_target;
      end
   end

   // successor set of a state set over both symbols
   always_comb begin
      succ_src = cmd.seed ? (NUM_STATES'(1) << cur_ff) : reached_ff;
      succ_set = '0;
      for (int i = 0; i < NUM_STATES; i++) begin
         if (succ_src[i]) begin
            succ_set[next0_ff[i]] = 1'b1;
            succ_set[next1_ff[i]] = 1'b1;
         end
      end
   end

   // reached set accumulation
   always_comb begin
      reached_in = reached_ff;
      if (cmd.seed) begin
         reached_in = succ_set;
      end else if (cmd.expand) begin
         reached_in = reached_ff | succ_set;
      end
   end

   always_ff @(posedge clock) begin
      reached_ff <= reached_in;
   end

   // item evaluation
   always_comb begin
      unreach    = ~reached_ff;
      step_next  = symbol_ff ? next1_ff[cur_ff] : next0_ff[cur_ff];
      step_ok    = valid_ff[step_next];
      tgt_idx    = SW'(target_ff);
      tgt_ok     = (32'(target_ff) < NUM_STATES) && valid_ff[tgt_idx];
      cur_in     = cur_ff;
      valid_in   = valid_ff;
      tbl_wr     = 1'b0;
      refused_in = 1'b0;
      mask_in    = '0;
      case (kind_type'(kind_ff))
         KIND_STEP: begin
            if (step_ok) cur_in = step_next;
            else refused_in = 1'b1;
         end
         KIND_CHANGE: begin
            if (tgt_ok) tbl_wr = 1'b1;
            else refused_in = 1'b1;
         end
         KIND_QUERY: begin
            mask_in = 8'(unreach);
         end
         KIND_DELETE: begin
            if (tgt_ok) valid_in[tgt_idx] = 1'b0;
            else refused_in = 1'b1;
         end
         KIND_PRUNE: begin
            mask_in  = 8'(unreach);
            valid_in = valid_ff & reached_ff;
         end
         default: begin
            refused_in = 1'b0;
         end
      endcase
   end

   // current state and valid bits, updated when the result is issued
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff   <= SW'(RESET_STATE % NUM_STATES);
         valid_ff <= '1;
      end else if (cmd.finish) begin
         cur_ff   <= cur_in;
         valid_ff <= valid_in;
      end
   end

   // transition table
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_STATES; i++) begin
            next0_ff[i] <= SW'(pfsm_reset_next(1'b0, i) % NUM_STATES);
            next1_ff[i] <= SW'(pfsm_reset_next(1'b1, i) % NUM_STATES);
         end
      end else if (cmd.finish && tbl_wr) begin
         if (symbol_ff) next1_ff[cur_ff] <= tgt_idx;
         else next0_ff[cur_ff] <= tgt_idx;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_state_ff   <= 3'(cur_in);
         rsp_refused_ff <= refused_in;
         rsp_mask_ff    <= mask_in;
      end
   end

   assign status.is_reach = (kind_ff == KIND_QUERY) || (kind_ff == KIND_PRUNE);
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_current_state    = rsp_state_ff;
   assign rsp_refused          = rsp_refused_ff;
   assign rsp_unreachable_mask = rsp_mask_ff;
   assign rsp_any_unreachable  = |rsp_mask_ff;

endmodule

/* src/pfsm_checker.sv */
// port-level assertions for the programmable state machine, bound to the top level
module pfsm_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_current_state,
   input logic       rsp_refused,
   input logic [7:0] rsp_unreachable_mask,
   input logic       rsp_any_unreachable
);

   // one request in flight: stall rises right after an accept
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while another was in flight");

   // summary flag agrees with the mask
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_any_unreachable == (rsp_unreachable_mask != 8'd0)))
      else $error("any_unreachable disagrees with mask");

   // refused items never report a mask
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_refused) |-> (rsp_unreachable_mask == 8'd0))
      else $error("refused result carries a mask");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_current_state)
                                    && $stable(rsp_refused)
                                    && $stable(rsp_unreachable_mask)))
      else $error("stalled result changed");

endmodule

bind programmable_fsm_with_reachability_prune pfsm_checker u_pfsm_checker (.*);

/* dv/testbench.sv */
// self-checking testbench for the programmable state machine with reachability pruning
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import pfsm_pkg::*;

   localparam int unsigned STATE_COUNT    = 8;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned DRAIN_CYCLES   = 2 * (STATE_COUNT + 3);
   localparam int unsigned PHASE_A_ITEMS  = 1150;
   localparam int unsigned PHASE_B_ITEMS  = 600;
   localparam int unsigned DIRECTED_ROWS  = 24;

   // kinds with no effect on the machine
   localparam logic [2:0] KIND_SPARE5 = 3'd5;
   localparam logic [2:0] KIND_SPARE6 = 3'd6;
   localparam logic [2:0] KIND_SPARE7 = 3'd7;

   typedef struct packed {
      logic [2:0] state;
      logic       refused;
      logic [7:0] mask;
      logic       any;
   } fsm_result;

   typedef struct packed {
      logic [2:0] kind;
      logic       symbol;
      logic [2:0] target;
      logic       typed;
      fsm_result  res;
   } stim_row;

   localparam fsm_result NO_RES = '0;

   // directed requests; typed rows carry a hand-worked answer
   localparam stim_row DIRECTED [DIRECTED_ROWS] = '{
      // query straight after reset: everything reachable from F
      '{KIND_QUERY,  1'b0, 3'd0, 1'b1, '{3'd5, 1'b0, 8'h00, 1'b0}},
      // spare kinds leave the machine alone
      '{KIND_SPARE5, 1'b1, 3'd7, 1'b1, '{3'd5, 1'b0, 8'h00, 1'b0}},
      '{KIND_SPARE6, 1'b0, 3'd0, 1'b1, '{3'd5, 1'b0, 8'h00, 1'b0}},
      '{KIND_SPARE7, 1'b1, 3'd5, 1'b1, '{3'd5, 1'b0, 8'h00, 1'b0}},
      // F -0-> G -1-> H
      '{KIND_STEP,   1'b0, 3'd0, 1'b1, '{3'd6, 1'b0, 8'h00, 1'b0}},
      '{KIND_STEP,   1'b1, 3'd0, 1'b1, '{3'd7, 1'b0, 8'h00, 1'b0}},
      // delete A, then delete it again
      '{KIND_DELETE, 1'b0, 3'd0, 1'b1, '{3'd7, 1'b0, 8'h00, 1'b0}},
      '{KIND_DELETE, 1'b1, 3'd0, 1'b1, '{3'd7, 1'b1, 8'h00, 1'b0}},
      // H -0-> F, then a change towards the deleted A
      '{KIND_STEP,   1'b0, 3'd0, 1'b1, '{3'd5, 1'b0, 8'h00, 1'b0}},
      '{KIND_CHANGE, 1'b0, 3'd0, 1'b1, '{3'd5, 1'b1, 8'h00, 1'b0}},
      // F -1-> B -1-> D -1-> C
      '{KIND_STEP,   1'b1, 3'd0, 1'b1, '{3'd1, 1'b0, 8'h00, 1'b0}},
      '{KIND_STEP,   1'b1, 3'd0, 1'b0, NO_RES},
      '{KIND_STEP,   1'b1, 3'd0, 1'b0, NO_RES},
      // C -0-> A is refused
      '{KIND_STEP,   1'b0, 3'd0, 1'b0, NO_RES},
      // rewire C and look at the unreachable set
      '{KIND_CHANGE, 1'b1, 3'd7, 1'b0, NO_RES},
      '{KIND_CHANGE, 1'b0, 3'd2, 1'b0, NO_RES},
      '{KIND_QUERY,  1'b0, 3'd0, 1'b0, NO_RES},
      '{KIND_CHANGE, 1'b1, 3'd2, 1'b0, NO_RES},
      '{KIND_QUERY,  1'b1, 3'd0, 1'b0, NO_RES},
      '{KIND_CHANGE, 1'b1, 3'd3, 1'b0, NO_RES},
      '{KIND_PRUNE,  1'b0, 3'd0, 1'b0, NO_RES},
      // delete the current state, then step out of it
      '{KIND_DELETE, 1'b0, 3'd2, 1'b0, NO_RES},
      '{KIND_STEP,   1'b1, 3'd0, 1'b0, NO_RES},
      '{KIND_QUERY,  1'b0, 3'd0, 1'b0, NO_RES}
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [2:0] req_kind = 3'd0;
   logic       req_symbol = 1'b0;
   logic [2:0] req_target = 3'd0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [2:0] rsp_current_state;
   logic       rsp_refused;
   logic [7:0] rsp_unreachable_mask;
   logic       rsp_any_unreachable;

   // predicted machine state
   logic [2:0] fsm_cur;
   logic [2:0] fsm_next0 [STATE_COUNT];
   logic [2:0] fsm_next1 [STATE_COUNT];
   logic [7:0] fsm_alive;

   fsm_result   awaited_q [$];
   int unsigned error_count = 0;
   int unsigned idle_cycles = 0;
   int unsigned rsp_hold_left = 0;
   bit          calm = 1'b0;

   programmable_fsm_with_reachability_prune #(
      .NUM_STATES(STATE_COUNT)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_kind(req_kind),
      .req_symbol(req_symbol),
      .req_target(req_target),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_current_state(rsp_current_state),
      .rsp_refused(rsp_refused),
      .rsp_unreachable_mask(rsp_unreachable_mask),
      .rsp_any_unreachable(rsp_any_unreachable)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // idle length: mostly none or short, now and then long
   function automatic int unsigned idle_length();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 50) begin
         return 0;
      end else if (r < 88) begin
         return $urandom_range(3, 1);
      end
      return $urandom_range(30, 8);
   endfunction

   function automatic bit state_alive(input logic [2:0] s);
      return (int'(s) < STATE_COUNT) && fsm_alive[s];
   endfunction

   // states one transition away from any state in the set
   function automatic logic [7:0] successors_of(input logic [7:0] set);
      logic [7:0] out;
      out = '0;
      for (int i = 0; i < STATE_COUNT; i++) begin
         if (set[i]) begin
            out[fsm_next0[i]] = 1'b1;
            out[fsm_next1[i]] = 1'b1;
         end
      end
      return out;
   endfunction

   // states not reached by a path of one or more transitions, deleted ones included
   function automatic logic [7:0] unreachable_from_current();
      logic [7:0] reached;
      reached = successors_of(8'd1 << fsm_cur);
      repeat (STATE_COUNT) reached |= successors_of(reached);
      return ~reached;
   endfunction

   // apply one request to the predicted machine and give its answer
   task automatic advance_fsm(input logic [2:0] kind, input logic sym, input logic [2:0] tgt,
                              output fsm_result r);
      logic [2:0] nxt;
      r = '0;
      case (kind)
         KIND_STEP: begin
            nxt = sym ? fsm_next1[fsm_cur] : fsm_next0[fsm_cur];
            if (state_alive(nxt)) begin
               fsm_cur = nxt;
            end else begin
               r.refused = 1'b1;
            end
         end
         KIND_CHANGE: begin
            if (!state_alive(tgt)) begin
               r.refused = 1'b1;
            end else if (sym) begin
               fsm_next1[fsm_cur] = tgt;
            end else begin
               fsm_next0[fsm_cur] = tgt;
            end
         end
         KIND_QUERY: begin
            r.mask = unreachable_from_current();
         end
         KIND_DELETE: begin
            if (state_alive(tgt)) begin
               fsm_alive[tgt] = 1'b0;
            end else begin
               r.refused = 1'b1;
            end
         end
         KIND_PRUNE: begin
            r.mask = unreachable_from_current();
            fsm_alive &= ~r.mask;
         end
         default: begin
         end
      endcase
      r.state = fsm_cur;
      r.any   = |r.mask;
   endtask

   // random state that is, or is not, still valid
   function automatic logic [2:0] pick_state(input bit alive);
      logic [2:0] s;
      s = '0;
      repeat (64) begin
         s = 3'($urandom_range(7));
         if (fsm_alive[s] == alive) begin
            return s;
         end
      end
      return s;
   endfunction

   // random request; deletes of live states and prunes only when allowed
   task automatic pick_request(input bit allow_kill, output logic [2:0] kind,
                               output logic sym, output logic [2:0] tgt);
      int unsigned r;
      r   = allow_kill ? $urandom_range(99) : $urandom_range(91);
      sym = 1'($urandom_range(1));
      tgt = 3'($urandom_range(7));
      if (r < 40) begin
         kind = KIND_STEP;
      end else if (r < 65) begin
         kind = KIND_CHANGE;
         if ($urandom_range(4) != 0) begin
            tgt = pick_state(1'b1);
         end
      end else if (r < 80) begin
         kind = KIND_QUERY;
      end else if (r < 86) begin
         kind = 3'($urandom_range(KIND_SPARE7, KIND_SPARE5));
      end else if (r < 92) begin
         // delete of a state that is already gone
         if (fsm_alive != 8'hFF) begin
            kind = KIND_DELETE;
            tgt  = pick_state(1'b0);
         end else begin
            kind = KIND_QUERY;
         end
      end else if (r < 97) begin
         kind = KIND_DELETE;
      end else begin
         kind = KIND_PRUNE;
      end
   endtask

   // present one request, wait for it to be taken, record its answer
   task automatic send_request(input logic [2:0] kind, input logic sym, input logic [2:0] tgt,
                               input logic typed, input fsm_result typed_res);
      int unsigned gap;
      fsm_result   res;
      gap = calm ? 0 : idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_kind   <= kind;
      req_symbol <= sym;
      req_target <= tgt;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      advance_fsm(kind, sym, tgt, res);
      awaited_q.push_back(typed ? typed_res : res);
   endtask

   // sender holds off until every answer is back
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_q.size() != 0) @(posedge clock);
   endtask

   task automatic report_field(input string name, input int unsigned want,
                               input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   // result side: check each accepted result, then choose the next stall
   always @(posedge clock) begin
      fsm_result want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, got state %0d refused %0d mask %h",
                     $time, rsp_current_state, rsp_refused, rsp_unreachable_mask);
            error_count++;
         end else begin
            want = awaited_q.pop_front();
            report_field("current_state", 32'(want.state), 32'(rsp_current_state));
            report_field("refused", 32'(want.refused), 32'(rsp_refused));
            report_field("unreachable_mask", 32'(want.mask), 32'(rsp_unreachable_mask));
            report_field("any_unreachable", 32'(want.any), 32'(rsp_any_unreachable));
         end
      end
      if (reset || calm) begin
         rsp_hold_left = 0;
         rsp_stall <= 1'b0;
      end else if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_hold_left = idle_length();
         rsp_stall <= (rsp_hold_left > 0);
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
         end
      end
   end

   // watchdog on cycles with no request or result taken
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("%0t: timeout, %0d results outstanding", $time, awaited_q.size());
         $display("testbench: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // stimulus
   initial begin
      logic [2:0] kind;
      logic       sym;
      logic [2:0] tgt;

      // predictor reset state
      for (int i = 0; i < STATE_COUNT; i++) begin
         fsm_next0[i] = RESET_NEXT0[i];
         fsm_next1[i] = RESET_NEXT1[i];
      end
      fsm_cur   = 3'(RESET_STATE);
      fsm_alive = '1;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed part
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         send_request(DIRECTED[i].kind, DIRECTED[i].symbol, DIRECTED[i].target,
                      DIRECTED[i].typed, DIRECTED[i].res);
      end
      hold_until_drained();

      // random part: first without losing live states, then with deletes and prunes
      for (int phase = 0; phase < 2; phase++) begin
         for (int n = 0; n < (phase == 0 ? PHASE_A_ITEMS : PHASE_B_ITEMS); n++) begin
            if (n % 100 == 0) begin
               calm = ($urandom_range(3) == 0);
            end
            if ($urandom_range(99) == 0) begin
               hold_until_drained();
            end
            pick_request(phase == 1, kind, sym, tgt);
            send_request(kind, sym, tgt, 1'b0, NO_RES);
         end
         hold_until_drained();
      end

      calm = 1'b0;
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
